// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file of the tone generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, ignored while reset is high.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== src/mctg_pkg.sv =====
// Types, register codes and sine table function of the tone generator.
package mctg_pkg;

   localparam int HW_CH   = 2;
   localparam int PHASE_W = 32;
   localparam int GAIN_W  = 31;
   localparam int SMPL_W  = 32;
   localparam int DATA_W  = 16;

   localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef enum logic [2:0] {
      CSR_ACTIVE_CHANNELS,
      CSR_SAMPLE_BYTES,
      CSR_WORD_MODE,
      CSR_STEP_CH0,
      CSR_GAIN_CH0,
      CSR_STEP_CH1,
      CSR_GAIN_CH1
   } csr_index_type;

   typedef struct packed {
      logic                            last_chan;
      logic [2:0]                      bytes;
      logic                            word_mode;
      logic [HW_CH-1:0][PHASE_W-1:0]   step;
      logic [HW_CH-1:0][GAIN_W-1:0]    gain;
   } cfg_type;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic               chan;
      logic               last;
   } job_type;

   typedef struct packed {
      logic [DATA_W-1:0] data;
      logic              chan;
      logic              last;
   } rsp_type;

   // Quarter-wave sine entry: Q30 Taylor series, clamped, rounded to the amplitude.
   function automatic logic [31:0] sine_entry(input int unsigned k,
                                              input int unsigned addr_bits,
                                              input int unsigned sine_bits);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] amp;
      x   = (HALF_PI_Q30 * 64'(k)) >> addr_bits;
      x2  = (x * x) >> 30;
      t   = ONE_Q30;
      t   = ONE_Q30 - ((x2 * t) >> 30) / 64'd156;
      t   = ONE_Q30 - ((x2 * t) >> 30) / 64'd110;
      t   = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
      t   = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
      t   = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
      t   = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
      s   = (x * t) >> 30;
      if (s > ONE_Q30) begin
         s = ONE_Q30;
      end
      amp = (64'd1 << (sine_bits - 1)) - 64'd1;
      return 32'((s * amp + (ONE_Q30 >> 1)) >> 30);
   endfunction

endpackage

// ===== src/mctg_queue.sv =====
// Small first-in first-out queue used after each stage of the tone generator.
module mctg_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ===== src/mctg_front.sv =====
// Front end: takes ticks, keeps the phase accumulators and issues one job per channel.
module mctg_front import mctg_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  logic    restart,
   output logic    full,
   input  cfg_type cfg,
   output job_type job,
   output logic    job_push,
   input  logic    job_full
);

   logic [PHASE_W-1:0] phase_ff [HW_CH];
   logic [PHASE_W-1:0] phase_in [HW_CH];
   logic               chan_ff, chan_in;
   logic               pending_ff, pending_in;
   logic               accept;

   assign job.phase = phase_ff[chan_ff];
   assign job.chan  = chan_ff;
   assign job.last  = (chan_ff == cfg.last_chan);
   assign job_push  = pending_ff && !job_full;
   assign full      = pending_ff && !(job_push && job.last);
   assign accept    = push && !full;

   always_comb begin
      phase_in   = phase_ff;
      chan_in    = chan_ff;
      pending_in = pending_ff;
      if (job_push) begin
         phase_in[chan_ff] = phase_ff[chan_ff] + cfg.step[chan_ff];
         chan_in           = chan_ff + 1'b1;
         if (job.last) begin
            pending_in = 1'b0;
         end
      end
      if (accept) begin
         pending_in = 1'b1;
         chan_in    = 1'b0;
         if (restart) begin
            for (int i = 0; i < HW_CH; i++) begin
               phase_in[i] = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HW_CH; i++) begin
            phase_ff[i] <= '0;
         end
         chan_ff    <= 1'b0;
         pending_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         chan_ff    <= chan_in;
         pending_ff <= pending_in;
      end
   end

endmodule

// ===== src/mctg_back.sv =====
// Back end: sine table read, gain multiply, sign and byte or word serialisation.
module mctg_back import mctg_pkg::*; #(
   parameter int SINE_ADDR_BITS = 10,
   parameter int SINE_BITS      = 24
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  job_type job,
   input  logic    job_empty,
   output logic    job_pop,
   output rsp_type rsp,
   output logic    rsp_push,
   input  logic    rsp_full
);

   localparam int ROM_SIZE = (1 << SINE_ADDR_BITS) + 1;
   localparam int IDX_W    = SINE_ADDR_BITS + 1;
   localparam int ROM_W    = SINE_BITS - 1;
   localparam int PROD_W   = GAIN_W + ROM_W;
   localparam logic [IDX_W-1:0] ROM_TOP = IDX_W'(1 << SINE_ADDR_BITS);

   logic [ROM_W-1:0] sine_table [ROM_SIZE];

   for (genvar k = 0; k < ROM_SIZE; k++) begin : g_rom
      localparam logic [ROM_W-1:0] Entry =
         ROM_W'(sine_entry(k, SINE_ADDR_BITS, SINE_BITS));
      assign sine_table[k] = Entry;
   end

   logic                      s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic                      s1_ready, s2_ready, s3_ready;
   logic [ROM_W-1:0]          rom_q_ff;
   logic [1:0]                s1_quad_ff;
   logic                      s1_chan_ff, s1_last_ff;
   logic [PROD_W-1:0]         prod_ff, prod_in;
   logic                      s2_neg_ff, s2_chan_ff, s2_last_ff;
   logic [SMPL_W-1:0]         sample_ff, sample_in;
   logic [1:0]                byte_ff, byte_in;
   logic                      s3_chan_ff, s3_last_ff;
   logic [SINE_ADDR_BITS-1:0] rom_addr;
   logic [IDX_W-1:0]          rom_idx;
   logic [SMPL_W-1:0]         mag;
   logic                      final_item;
   logic [2:0]                first_byte;

   assign rom_addr = job.phase[PHASE_W-3 -: SINE_ADDR_BITS];
   assign rom_idx  = job.phase[PHASE_W-2] ? (ROM_TOP - {1'b0, rom_addr}) : {1'b0, rom_addr};

   assign prod_in    = PROD_W'(cfg.gain[s1_chan_ff]) * PROD_W'(rom_q_ff);
   assign mag        = SMPL_W'(prod_ff[PROD_W-1:ROM_W]);
   assign sample_in  = s2_neg_ff ? (SMPL_W'(0) - mag) : mag;
   assign first_byte = 3'd4 - cfg.bytes;

   assign final_item = cfg.word_mode || (byte_ff == 2'd3);
   assign rsp_push   = s3_valid_ff && !rsp_full;
   assign s3_ready   = !s3_valid_ff || (rsp_push && final_item);
   assign s2_ready   = !s2_valid_ff || s3_ready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign job_pop    = !job_empty && s1_ready;

   assign rsp.data = cfg.word_mode ? sample_ff[SMPL_W-1 -: DATA_W]
                                   : {8'h00, sample_ff[8*byte_ff +: 8]};
   assign rsp.chan = s3_chan_ff;
   assign rsp.last = s3_last_ff && final_item;

   always_comb begin
      byte_in = byte_ff;
      if (s3_ready && s2_valid_ff) begin
         byte_in = first_byte[1:0];
      end else if (rsp_push) begin
         byte_in = byte_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= !job_empty;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         rom_q_ff   <= sine_table[rom_idx];
         s1_quad_ff <= job.phase[PHASE_W-1 -: 2];
         s1_chan_ff <= job.chan;
         s1_last_ff <= job.last;
      end
      if (s2_ready && s1_valid_ff) begin
         prod_ff    <= prod_in;
         s2_neg_ff  <= s1_quad_ff[1];
         s2_chan_ff <= s1_chan_ff;
         s2_last_ff <= s1_last_ff;
      end
      if (s3_ready && s2_valid_ff) begin
         sample_ff  <= sample_in;
         s3_chan_ff <= s2_chan_ff;
         s3_last_ff <= s2_last_ff;
      end
      byte_ff <= byte_in;
   end

endmodule

// ===== src/multichannel_tone_pcm_generator.sv =====
// Top level of the multichannel sine tone PCM generator.
//
// Each tick written on the request side (push while full is low) makes one
// frame of interleaved PCM items, one sample per active channel in channel
// order. A sample is one 16-bit word in word mode, otherwise its top one to
// four bytes, least significant of them first. req_restart zeroes every phase
// before the frame. The last item of each frame carries rsp_frame_last.
// Results are read like a queue: the oldest is shown while empty is low and
// leaves on an edge with pop high.
// The front end issues one job per active channel; the back end emits one
// item per cycle while the result queue has room. A frame has one to eight
// items, passed through the job queue, the back end's table read, gain
// multiply and output registers, and the result queue. The user must write
// registers through the csr port only while the block is idle; the block
// itself does not enforce this. When the receiver stalls, the internal queues
// fill and full rises; no item is lost. Reset empties both queues, zeroes
// the phases and loads the register defaults.
module multichannel_tone_pcm_generator import mctg_pkg::*; #(
   parameter int CHANNELS       = 2,
   parameter int SINE_ADDR_BITS = 10,
   parameter int SINE_BITS      = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic              req_restart,
   output logic              empty,
   input  logic              pop,
   output logic [DATA_W-1:0] rsp_out_data,
   output logic              rsp_out_channel,
   output logic              rsp_frame_last,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_wdata
);

   localparam bit MULTI_CH = (CHANNELS > 1);

   logic [1:0]         active_channels_ff;
   logic [2:0]         sample_bytes_ff;
   logic               word_mode_ff;
   logic [PHASE_W-1:0] step_ff [HW_CH];
   logic [GAIN_W-1:0]  gain_ff [HW_CH];
   logic [2:0]         bytes_eff;
   cfg_type            cfg;
   job_type            job_wr, job_rd;
   logic               job_push, job_full, job_pop, job_empty;
   rsp_type            rsp_wr, rsp_rd;
   logic               rsp_push, rsp_full;

   always_comb begin
      case (sample_bytes_ff) inside
         3'd0:         bytes_eff = 3'd1;
         [3'd5:3'd7]:  bytes_eff = 3'd4;
         default:      bytes_eff = sample_bytes_ff;
      endcase
   end

   always_comb begin
      cfg.last_chan = active_channels_ff[1] && MULTI_CH;
      cfg.bytes     = bytes_eff;
      cfg.word_mode = word_mode_ff;
      for (int i = 0; i < HW_CH; i++) begin
         cfg.step[i] = step_ff[i];
         cfg.gain[i] = gain_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_channels_ff <= 2'd1;
         sample_bytes_ff    <= 3'd2;
         word_mode_ff       <= 1'b0;
         for (int i = 0; i < HW_CH; i++) begin
            step_ff[i] <= '0;
            gain_ff[i] <= '0;
         end
      end else if (csr_we) begin
         case (csr_index)
            CSR_ACTIVE_CHANNELS: active_channels_ff <= csr_wdata[1:0];
            CSR_SAMPLE_BYTES:    sample_bytes_ff    <= csr_wdata[2:0];
            CSR_WORD_MODE:       word_mode_ff       <= csr_wdata[0];
            CSR_STEP_CH0:        step_ff[0]         <= csr_wdata;
            CSR_GAIN_CH0:        gain_ff[0]         <= csr_wdata[GAIN_W-1:0];
            CSR_STEP_CH1:        step_ff[1]         <= csr_wdata;
            CSR_GAIN_CH1:        gain_ff[1]         <= csr_wdata[GAIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   mctg_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .restart  (req_restart),
      .full     (full),
      .cfg      (cfg),
      .job      (job_wr),
      .job_push (job_push),
      .job_full (job_full)
   );

   mctg_queue #(
      .WIDTH ($bits(job_type)),
      .DEPTH (2)
   ) u_job_queue (
      .clock (clock),
      .reset (reset),
      .push  (job_push),
      .wdata (job_wr),
      .full  (job_full),
      .pop   (job_pop),
      .rdata (job_rd),
      .empty (job_empty)
   );

   mctg_back #(
      .SINE_ADDR_BITS (SINE_ADDR_BITS),
      .SINE_BITS      (SINE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .job       (job_rd),
      .job_empty (job_empty),
      .job_pop   (job_pop),
      .rsp       (rsp_wr),
      .rsp_push  (rsp_push),
      .rsp_full  (rsp_full)
   );

   mctg_queue #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (2)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_wr),
      .full  (rsp_full),
      .pop   (pop),
      .rdata (rsp_rd),
      .empty (empty)
   );

   assign rsp_out_data    = rsp_rd.data;
   assign rsp_out_channel = rsp_rd.chan;
   assign rsp_frame_last  = rsp_rd.last;

endmodule

// ===== src/mctg_checker.sv =====
// Port-level checker for the tone generator and its bind to the top level.
`include "assert_macros.svh"

module mctg_checker (
   input logic        clock,
   input logic        reset,
   input logic        full,
   input logic        empty,
   input logic        pop,
   input logic [15:0] rsp_out_data,
   input logic        rsp_out_channel,
   input logic        rsp_frame_last
);

   `ASSERT_CLK_ALWAYS(a_reset_idle, reset |=> empty && !full, "not idle after reset")
   `ASSERT_CLK(a_rsp_hold, !empty && !pop |=> !empty && $stable(rsp_out_data) && $stable(rsp_out_channel) && $stable(rsp_frame_last), "stalled result changed")
   `ASSERT_CLK(a_frame_start, pop && !empty && rsp_frame_last |=> empty || !rsp_out_channel, "frame did not start on channel zero")
   `ASSERT_CLK(a_chan_order, pop && !empty && !rsp_frame_last && rsp_out_channel |=> empty || rsp_out_channel, "channel order broken within a frame")

endmodule

bind multichannel_tone_pcm_generator mctg_checker u_checker (.*);
